// ===== rtl/core/lmd_pkg.sv =====
// ----------------------------------------------------------------------------
// lmd_pkg
// Shared types and constants for the 2x2 label mode downsampler.
// ----------------------------------------------------------------------------
package lmd_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned LABEL_BITS_DEF = 16;

  localparam int unsigned CFG_W        = 13;
  localparam int unsigned ROW_W        = 12;
  localparam int unsigned HEIGHT_LIMIT = 4096;
  localparam int unsigned CFG_RESET    = 4096;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

  // position flags of an item in flight
  typedef struct packed {
    logic odd_row;
    logic odd_col;
    logic last_col;
    logic last_row;
  } pos_flags_t;

endpackage

// ===== rtl/core/lmd_line_buf.sv =====
// ----------------------------------------------------------------------------
// lmd_line_buf
// One-row label store, single port, registered read.
// ----------------------------------------------------------------------------
module lmd_line_buf #(
  parameter int unsigned DEPTH  = lmd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned DATA_W = lmd_pkg::LABEL_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/lmd_mode_pick.sv =====
// ----------------------------------------------------------------------------
// lmd_mode_pick
// Mode of four labels with fixed tie order: top-left, top-right, bottom-left.
// ----------------------------------------------------------------------------
module lmd_mode_pick #(
  parameter int unsigned LABEL_BITS = lmd_pkg::LABEL_BITS_DEF
) (
  input  logic [LABEL_BITS-1:0] tl_i,
  input  logic [LABEL_BITS-1:0] tr_i,
  input  logic [LABEL_BITS-1:0] bl_i,
  input  logic [LABEL_BITS-1:0] br_i,
  output logic [LABEL_BITS-1:0] mode_o
);

  always_comb begin
    if ((tr_i == tl_i) || (bl_i == tl_i) || (br_i == tl_i)) begin
      mode_o = tl_i;
    end else if ((bl_i == tr_i) || (br_i == tr_i)) begin
      mode_o = tr_i;
    end else if (br_i == bl_i) begin
      mode_o = bl_i;
    end else begin
      mode_o = tl_i;
    end
  end

endmodule

// ===== rtl/core/label_mode_downsample_2x2.sv =====
// ----------------------------------------------------------------------------
// label_mode_downsample_2x2
// Halves a raster label image; each output label is the mode of a 2x2 block.
//
//  channel   dir  handshake                       payload
//  pixel     in   pixel_valid_i / pixel_ready_o   pixel_label_i
//  result    out  result_valid_o / result_ready_i mode_label_o, end_of_row_o,
//                                                 end_of_frame_o
//  cfg       in   cfg_we_i (no wait)              cfg_idx_i, cfg_wdata_i
//
// One item per cycle. An item passes the counter/line-buffer read stage and
// the mode stage; any result that it yields is held in the output register.
// The line buffer port is used once per item.
// Reset clears counters and valid flags; no buffer clearing is needed.
// A stalled result holds the mode stage; input stalls once that stage is full.
// ----------------------------------------------------------------------------
module label_mode_downsample_2x2 #(
  parameter int unsigned MAX_WIDTH  = lmd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned LABEL_BITS = lmd_pkg::LABEL_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_idx_i,
  input  logic [lmd_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                        pixel_valid_i,
  output logic                        pixel_ready_o,
  input  logic [LABEL_BITS-1:0]       pixel_label_i,
  output logic                        result_valid_o,
  input  logic                        result_ready_i,
  output logic [LABEL_BITS-1:0]       mode_label_o,
  output logic                        end_of_row_o,
  output logic                        end_of_frame_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WB = (CW + 1 > lmd_pkg::CFG_W) ? CW + 1 : lmd_pkg::CFG_W;
  localparam int unsigned HB = lmd_pkg::ROW_W + 1;

  // configuration
  logic [lmd_pkg::CFG_W-1:0] cfg_width_q, cfg_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= lmd_pkg::CFG_W'(lmd_pkg::CFG_RESET);
      cfg_height_q <= lmd_pkg::CFG_W'(lmd_pkg::CFG_RESET);
    end else if (cfg_we_i) begin
      unique case (lmd_pkg::reg_idx_e'(cfg_idx_i))
        lmd_pkg::REG_IMAGE_WIDTH:  cfg_width_q  <= cfg_wdata_i;
        lmd_pkg::REG_IMAGE_HEIGHT: cfg_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stage 0: position and line buffer access
  logic [CW-1:0]             col_q, col_d, col_c;
  logic [lmd_pkg::ROW_W-1:0] row_q, row_d;
  logic [WB-1:0]             width_ext, width_eff;
  logic [HB-1:0]             height_eff;
  logic                      last_col, last_row;
  logic                      in_acc;
  logic                      s1_adv;

  always_comb begin
    width_ext = WB'(cfg_width_q);
    if (width_ext == '0) begin
      width_eff = WB'(1);
    end else if (width_ext > WB'(MAX_WIDTH)) begin
      width_eff = WB'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    if (cfg_height_q == '0) begin
      height_eff = HB'(1);
    end else if (HB'(cfg_height_q) > HB'(lmd_pkg::HEIGHT_LIMIT)) begin
      height_eff = HB'(lmd_pkg::HEIGHT_LIMIT);
    end else begin
      height_eff = HB'(cfg_height_q);
    end
    col_c    = (col_q > CW'(MAX_WIDTH - 1)) ? CW'(MAX_WIDTH - 1) : col_q;
    last_col = (WB'(col_c) + WB'(1)) >= width_eff;
    last_row = (HB'(row_q) + HB'(1)) >= height_eff;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + lmd_pkg::ROW_W'(1);
      end else begin
        col_d = col_c + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  logic [LABEL_BITS-1:0] store_rd;

  lmd_line_buf #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (LABEL_BITS)
  ) u_line_buf (
    .clk_i   (clk_i),
    .wr_en_i (in_acc && !row_q[0]),
    .rd_en_i (in_acc),
    .addr_i  (col_c),
    .wdata_i (pixel_label_i),
    .rdata_o (store_rd)
  );

  // stage 1 register
  logic                  s1_valid_q;
  logic [LABEL_BITS-1:0] s1_label_q;
  lmd_pkg::pos_flags_t   s1_flags_q;

  assign pixel_ready_o = !s1_valid_q || s1_adv;
  assign in_acc        = pixel_valid_i && pixel_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pixel_ready_o) begin
      s1_valid_q <= pixel_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_label_q          <= pixel_label_i;
      s1_flags_q.odd_row  <= row_q[0];
      s1_flags_q.odd_col  <= col_c[0];
      s1_flags_q.last_col <= last_col;
      s1_flags_q.last_row <= last_row;
    end
  end

  // stage 1: block decision
  logic [LABEL_BITS-1:0] held_tl_q, held_tl_d;
  logic [LABEL_BITS-1:0] held_bl_q, held_bl_d;
  logic [LABEL_BITS-1:0] store_tl_q, store_tl_d;
  logic [LABEL_BITS-1:0] mode_pick;
  logic [LABEL_BITS-1:0] result;
  logic                  emit;

  lmd_mode_pick #(
    .LABEL_BITS (LABEL_BITS)
  ) u_mode_pick (
    .tl_i   (store_tl_q),
    .tr_i   (store_rd),
    .bl_i   (held_bl_q),
    .br_i   (s1_label_q),
    .mode_o (mode_pick)
  );

  always_comb begin
    held_tl_d  = held_tl_q;
    held_bl_d  = held_bl_q;
    store_tl_d = store_tl_q;
    result     = s1_label_q;
    emit       = 1'b0;
    if (!s1_flags_q.odd_row) begin
      if (s1_flags_q.odd_col) begin
        result = held_tl_q;
        emit   = s1_flags_q.last_row;
      end else begin
        held_tl_d = s1_label_q;
        result    = s1_label_q;
        emit      = s1_flags_q.last_row && s1_flags_q.last_col;
      end
    end else begin
      if (s1_flags_q.odd_col) begin
        result = mode_pick;
        emit   = 1'b1;
      end else begin
        held_bl_d  = s1_label_q;
        store_tl_d = store_rd;
        result     = store_rd;
        emit       = s1_flags_q.last_col;
      end
    end
  end

  assign s1_adv = s1_valid_q && (!result_valid_o || result_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_tl_q  <= '0;
      held_bl_q  <= '0;
      store_tl_q <= '0;
    end else if (s1_adv) begin
      held_tl_q  <= held_tl_d;
      held_bl_q  <= held_bl_d;
      store_tl_q <= store_tl_d;
    end
  end

  // output register
  logic out_valid_q, out_valid_d;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && result_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (s1_adv) begin
      out_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && emit) begin
      mode_label_o   <= result;
      end_of_row_o   <= s1_flags_q.last_col;
      end_of_frame_o <= s1_flags_q.last_col && s1_flags_q.last_row;
    end
  end

  assign result_valid_o = out_valid_q;

  // checks
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !result_ready_i |-> !pixel_ready_o)
    else $error("input taken while mode stage is stalled");

  a_eof_is_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && end_of_frame_o |-> end_of_row_o)
    else $error("end of frame without end of row");

  a_col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_col |=> col_q == '0)
    else $error("column counter did not wrap");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_col && last_row |=> row_q == '0)
    else $error("row counter did not wrap at frame end");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for label_mode_downsample_2x2. A queue-fed driver offers label
// pixels; every accepted pixel runs through a local 2x2 mode predictor whose
// results are checked, in order and field by field, against the result port.
// Directed frames cover the tie rules, odd edges, a width change mid-frame
// and out-of-range sizes; random frames follow, then oversized size
// registers. Both sides idle at random and the result side holds off once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned LB    = lmd_pkg::LABEL_BITS_DEF;
  localparam int unsigned MAX_W = lmd_pkg::MAX_WIDTH_DEF;

  typedef struct {
    logic [LB-1:0] mode_label;
    logic          end_of_row;
    logic          end_of_frame;
  } mode_result_t;

  logic                      clk_i          = 1'b0;
  logic                      rst_ni         = 1'b0;
  logic                      cfg_we_i       = 1'b0;
  logic [0:0]                cfg_idx_i      = '0;
  logic [lmd_pkg::CFG_W-1:0] cfg_wdata_i    = '0;
  logic                      pixel_valid_i  = 1'b0;
  logic                      pixel_ready_o;
  logic [LB-1:0]             pixel_label_i  = '0;
  logic                      result_valid_o;
  logic                      result_ready_i = 1'b0;
  logic [LB-1:0]             mode_label_o;
  logic                      end_of_row_o;
  logic                      end_of_frame_o;

  // predictor state
  logic [LB-1:0]             row_store [MAX_W];
  int unsigned               col_cnt    = 0;
  int unsigned               row_cnt    = 0;
  logic [LB-1:0]             held_tl    = '0;
  logic [LB-1:0]             held_bl    = '0;
  logic [lmd_pkg::CFG_W-1:0] cfg_width  = lmd_pkg::CFG_W'(lmd_pkg::CFG_RESET);
  logic [lmd_pkg::CFG_W-1:0] cfg_height = lmd_pkg::CFG_W'(lmd_pkg::CFG_RESET);

  logic [LB-1:0]    pending_pixels [$];
  mode_result_t     expected_modes [$];
  mode_result_t     exp_res;
  int unsigned      mismatches   = 0;
  int unsigned      results_seen = 0;
  int unsigned      hold_left    = 0;
  bit               hold_done    = 1'b0;
  bit               idle_on      = 1'b1;

  label_mode_downsample_2x2 u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .pixel_valid_i  (pixel_valid_i),
    .pixel_ready_o  (pixel_ready_o),
    .pixel_label_i  (pixel_label_i),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .mode_label_o   (mode_label_o),
    .end_of_row_o   (end_of_row_o),
    .end_of_frame_o (end_of_frame_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic queue_pixel(input logic [LB-1:0] px);
    pending_pixels.insert(pending_pixels.size(), px);
  endtask

  task automatic predict_block_mode(input logic [LB-1:0] px);
    int unsigned   w;
    int unsigned   h;
    logic          lc;
    logic          lr;
    logic          emit;
    logic [LB-1:0] a;
    logic [LB-1:0] b;
    logic [LB-1:0] c;
    logic [LB-1:0] res;
    mode_result_t  item;
    w = cfg_width;
    h = cfg_height;
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    if (h == 0) h = 1;
    if (h > lmd_pkg::HEIGHT_LIMIT) h = lmd_pkg::HEIGHT_LIMIT;
    lc   = (col_cnt + 1 >= w);
    lr   = (row_cnt + 1 >= h);
    emit = 1'b0;
    res  = '0;
    if (row_cnt % 2 == 0) begin
      row_store[col_cnt] = px;
      if (col_cnt % 2 == 1) begin
        if (lr) begin
          res  = held_tl;
          emit = 1'b1;
        end
      end else begin
        held_tl = px;
        if (lr && lc) begin
          res  = px;
          emit = 1'b1;
        end
      end
    end else if (col_cnt % 2 == 1) begin
      a = row_store[col_cnt - 1];
      b = row_store[col_cnt];
      c = held_bl;
      if (b == a || c == a || px == a) res = a;
      else if (c == b || px == b) res = b;
      else if (px == c) res = c;
      else res = a;
      emit = 1'b1;
    end else begin
      held_bl = px;
      if (lc) begin
        res  = row_store[col_cnt];
        emit = 1'b1;
      end
    end
    if (emit) begin
      item.mode_label   = res;
      item.end_of_row   = lc;
      item.end_of_frame = lc && lr;
      expected_modes.insert(expected_modes.size(), item);
    end
    if (lc) begin
      col_cnt = 0;
      row_cnt = lr ? 0 : ((row_cnt + 1) & 'hFFF);
    end else begin
      col_cnt = (col_cnt + 1) & 'hFFF;
    end
  endtask

  // pixel driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_valid_i <= 1'b0;
    end else begin
      if (pixel_valid_i && pixel_ready_o) predict_block_mode(pixel_label_i);
      if (!pixel_valid_i || pixel_ready_o) begin
        if (pending_pixels.size() != 0 && !(idle_on && $urandom_range(99) < 19)) begin
          pixel_valid_i <= 1'b1;
          pixel_label_i <= pending_pixels.pop_front();
        end else begin
          pixel_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_ready_i <= 1'b0;
    end else begin
      if (result_valid_o && result_ready_i) begin
        if (expected_modes.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual mode_label %h", $time,
                   mode_label_o);
          mismatches++;
        end else begin
          exp_res = expected_modes.pop_front();
          if (mode_label_o !== exp_res.mode_label) begin
            $display("%0t: mode_label expected %h actual %h", $time,
                     exp_res.mode_label, mode_label_o);
            mismatches++;
          end
          if (end_of_row_o !== exp_res.end_of_row) begin
            $display("%0t: end_of_row expected %b actual %b", $time,
                     exp_res.end_of_row, end_of_row_o);
            mismatches++;
          end
          if (end_of_frame_o !== exp_res.end_of_frame) begin
            $display("%0t: end_of_frame expected %b actual %b", $time,
                     exp_res.end_of_frame, end_of_frame_o);
            mismatches++;
          end
        end
        results_seen++;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_ready_i <= 1'b0;
      end else if (!hold_done && results_seen >= 120) begin
        hold_done = 1'b1;
        hold_left = 250;
        result_ready_i <= 1'b0;
      end else begin
        result_ready_i <= !(idle_on && $urandom_range(99) < 19);
      end
    end
  end

  task automatic write_reg(input lmd_pkg::reg_idx_e idx,
                           input logic [lmd_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == lmd_pkg::REG_IMAGE_WIDTH) cfg_width = val;
    else cfg_height = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // block idle: nothing queued or offered, every result in, then the pipe flushed
  task automatic wait_drained();
    while (pending_pixels.size() != 0 || pixel_valid_i || expected_modes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (6) @(posedge clk_i);
  endtask

  initial begin
    int unsigned   frame_w;
    int unsigned   frame_h;
    int unsigned   random_sent;
    int unsigned   frame_no;
    bit            narrow;
    logic [LB-1:0] palette [4];
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 6x2, width cut to 4 mid-frame; blocks: top-left by diagonal, top-right
    write_reg(lmd_pkg::REG_IMAGE_WIDTH, 13'd6);
    write_reg(lmd_pkg::REG_IMAGE_HEIGHT, 13'd2);
    queue_pixel(16'hFFFF); queue_pixel(16'h0000);
    queue_pixel(16'h0001); queue_pixel(16'h0007);
    queue_pixel(16'h8000); queue_pixel(16'h7FFF);
    queue_pixel(16'h0001); queue_pixel(16'hFFFF);
    wait_drained();
    write_reg(lmd_pkg::REG_IMAGE_WIDTH, 13'd4);
    queue_pixel(16'h0007); queue_pixel(16'h0002);
    wait_drained();

    // 3x3: bottom-left pair wins, odd last column, odd last row
    write_reg(lmd_pkg::REG_IMAGE_WIDTH, 13'd3);
    write_reg(lmd_pkg::REG_IMAGE_HEIGHT, 13'd3);
    queue_pixel(16'h0000); queue_pixel(16'h0001);
    queue_pixel(16'h0009); queue_pixel(16'h0002);
    queue_pixel(16'h0002); queue_pixel(16'h0004);
    queue_pixel(16'h000B); queue_pixel(16'h000C);
    queue_pixel(16'h000D);
    wait_drained();

    // 2x2 all distinct
    write_reg(lmd_pkg::REG_IMAGE_WIDTH, 13'd2);
    write_reg(lmd_pkg::REG_IMAGE_HEIGHT, 13'd2);
    queue_pixel(16'h0003); queue_pixel(16'h0004);
    queue_pixel(16'h0005); queue_pixel(16'h0006);
    wait_drained();

    // zero sizes act as 1x1
    write_reg(lmd_pkg::REG_IMAGE_WIDTH, 13'd0);
    write_reg(lmd_pkg::REG_IMAGE_HEIGHT, 13'd0);
    queue_pixel(16'hFFFF);
    wait_drained();

    random_sent = 0;
    frame_no    = 0;
    frame_w     = 1;
    frame_h     = 1;
    while (random_sent < 760) begin
      idle_on <= !(random_sent >= 300 && random_sent < 450);
      if (frame_no == 0 || $urandom_range(2) != 0) begin
        frame_w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        frame_h = $urandom_range(1, 9);
        wait_drained();
        write_reg(lmd_pkg::REG_IMAGE_WIDTH, lmd_pkg::CFG_W'(frame_w));
        write_reg(lmd_pkg::REG_IMAGE_HEIGHT, lmd_pkg::CFG_W'(frame_h));
      end
      narrow = $urandom_range(1);
      foreach (palette[i]) palette[i] = LB'($urandom);
      repeat (frame_w * frame_h) begin
        queue_pixel(narrow ? palette[$urandom_range(3)] : LB'($urandom));
      end
      random_sent += frame_w * frame_h;
      frame_no++;
    end
    idle_on <= 1'b1;

    // oversized registers: rows and frames run on, then close at a smaller size
    wait_drained();
    write_reg(lmd_pkg::REG_IMAGE_WIDTH, 13'h1FFF);
    write_reg(lmd_pkg::REG_IMAGE_HEIGHT, 13'd1);
    repeat (40) queue_pixel(LB'($urandom));
    wait_drained();
    write_reg(lmd_pkg::REG_IMAGE_WIDTH, 13'd41);
    queue_pixel(LB'($urandom));
    wait_drained();
    write_reg(lmd_pkg::REG_IMAGE_WIDTH, 13'd1);
    write_reg(lmd_pkg::REG_IMAGE_HEIGHT, 13'h1FFF);
    repeat (30) queue_pixel(LB'($urandom));
    wait_drained();
    write_reg(lmd_pkg::REG_IMAGE_HEIGHT, 13'd31);
    queue_pixel(LB'($urandom));

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_modes.size() == 0) begin
      $display("label_mode_downsample_2x2 test passed");
    end else begin
      $display("label_mode_downsample_2x2 test failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("label_mode_downsample_2x2 test failed");
    $finish;
  end

endmodule
